// File: hw/rtl/bmsm_pkg.sv
// Shared constants and controller/datapath interface types for the block mean unit.
`timescale 1ns / 1ps
`default_nettype none
package bmsm_pkg;

  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 32;
  localparam int USED_W   = 17;
  localparam int SUM_W    = 49;

  localparam int DIV_STEPS = SUM_W;
  localparam int ITER_W    = $clog2(DIV_STEPS);

  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef struct packed {
    logic acc_en;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/bmsm_datapath.sv
// Datapath: running sum and count, shift-subtract divider, saturation and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bmsm_datapath #(
  parameter int MAX_SAMPLES = bmsm_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = bmsm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bmsm_pkg::cmd_t                   cmd,
  output bmsm_pkg::sts_t                        sts,
  input  wire logic signed [bmsm_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                             in_missing,
  output logic signed [bmsm_pkg::MEAN_W-1:0]    out_mean,
  output logic [bmsm_pkg::USED_W-1:0]           out_used_count,
  output logic                                  out_empty_res,
  output logic                                  out_overflow
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int EFF_W = (SAMPLE_BITS < bmsm_pkg::SAMPLE_W) ? SAMPLE_BITS : bmsm_pkg::SAMPLE_W;
  localparam int SUM_W = bmsm_pkg::SUM_W;
  localparam int MW    = bmsm_pkg::MEAN_W;

  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [bmsm_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic [SUM_W-1:0]           quo_r;
  logic [CNT_W-1:0]           rem_r;
  logic                       neg_r;

  logic [SUM_W-1:0] samp_ext;
  logic             cnt_full;
  logic [SUM_W-1:0] sum_mag;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_sub;
  logic             fits;
  logic             pos_big;
  logic             neg_big;
  logic [SUM_W-1:0] quo_neg;
  logic [MW-1:0]    mean_sat;
  logic [31:0]      cnt_ext;

  always_comb begin
    samp_ext = {{(SUM_W-EFF_W){in_sample[EFF_W-1]}}, in_sample[EFF_W-1:0]};
    cnt_full = (cnt_r >= CNT_W'(MAX_SAMPLES));
    sum_mag  = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    fits     = (rem_sh >= {1'b0, cnt_r});
    rem_sub  = rem_sh - {1'b0, cnt_r};
    pos_big  = |quo_r[SUM_W-1:MW-1];
    neg_big  = (|quo_r[SUM_W-1:MW]) || (quo_r[MW-1] && (|quo_r[MW-2:0]));
    quo_neg  = ~quo_r + SUM_W'(1);
    if (neg_r) begin
      mean_sat = neg_big ? bmsm_pkg::MEAN_MIN : quo_neg[MW-1:0];
    end else begin
      mean_sat = pos_big ? bmsm_pkg::MEAN_MAX : quo_r[MW-1:0];
    end
    cnt_ext  = 32'(cnt_r);
    sts.div_done = (iter_r == '0);
  end

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    iter_nxt = iter_r;
    if (cmd.acc_en && !in_missing) begin
      if (cnt_full) begin
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_r + samp_ext;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.load) begin
      iter_nxt = bmsm_pkg::ITER_W'(bmsm_pkg::DIV_STEPS - 1);
    end else if (cmd.step && iter_r != '0) begin
      iter_nxt = iter_r - bmsm_pkg::ITER_W'(1);
    end
    if (cmd.finish) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      iter_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= sum_mag;
      rem_r <= '0;
      neg_r <= sum_r[SUM_W-1];
    end else if (cmd.step) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (cmd.finish) begin
      out_mean       <= (cnt_r == '0) ? '0 : mean_sat;
      out_used_count <= cnt_ext[bmsm_pkg::USED_W-1:0];
      out_empty_res  <= (cnt_r == '0);
      out_overflow   <= ovf_r;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bmsm_ctrl.sv
// Controller: sequences accumulation, division and the result beat handshake.
`timescale 1ns / 1ps
`default_nettype none
module bmsm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bmsm_pkg::cmd_t      cmd,
  input  wire bmsm_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_ACC,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  always_comb begin
    in_ready  = (state_r == S_ACC);
    out_valid = out_valid_r;
    accept    = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;

    cmd.acc_en = accept;
    cmd.load   = (state_r == S_LOAD);
    cmd.step   = (state_r == S_DIV);
    cmd.finish = (state_r == S_FIN) && out_free;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_ACC:  if (accept && in_last) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (sts.div_done) state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt     = S_ACC;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written while the previous beat was still pending");

  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (state_r == S_LOAD))
    else $error("final beat did not start the division");

  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (state_r == S_DIV && !sts.div_done))
    else $error("divider not armed after load");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && state_r == S_ACC))
    else $error("finished result not presented");

endmodule
`default_nettype wire

// File: hw/rtl/block_mean_skip_missing_unit.sv
// Top level of the block mean unit that skips missing samples.
// Sequence: after the last beat the controller loads the divider, runs its 49 steps
// and writes the result beat, waiting while a previous result beat is still pending.
// Throughput: one input beat per cycle within a block; after a last beat input stalls
// through the load, the one-bit-per-cycle division and the result write.
// Reset (rst_n, synchronous, active low) clears the sum, count, overflow flag and
// controller; the block then accepts input at once.
`timescale 1ns / 1ps
`default_nettype none
module block_mean_skip_missing_unit #(
  parameter int MAX_SAMPLES = bmsm_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = bmsm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [bmsm_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                                  in_missing,
  input  wire logic                                  in_last,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [bmsm_pkg::MEAN_W-1:0]         out_mean,
  output logic [bmsm_pkg::USED_W-1:0]                out_used_count,
  output logic                                       out_empty_res,
  output logic                                       out_overflow
);

  bmsm_pkg::cmd_t cmd;
  bmsm_pkg::sts_t sts;

  bmsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bmsm_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .in_missing     (in_missing),
    .out_mean       (out_mean),
    .out_used_count (out_used_count),
    .out_empty_res  (out_empty_res),
    .out_overflow   (out_overflow)
  );

endmodule
`default_nettype wire
